FILE: design/pcre_pkg.sv
// ----------------------------------------------------------------------------
// pcre_pkg
// Shared types and constants of the packed cel row run-length encoder:
// field widths, packet codes, datapath operations, command and status words
// and the controller state type.
// ----------------------------------------------------------------------------
package pcre_pkg;

    localparam int PIXEL_W              = 4;
    localparam int BYTE_W               = 8;
    localparam int ROW_WIDTH_W          = 6;
    localparam int NIB_BITS             = 4;
    localparam int MAX_ROW_PIXELS_DEF   = 32;
    localparam int ROW_BUFFER_BYTES_DEF = 64;

    localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 6'd32;

    // two-bit packet codes in the top of a packet header byte
    localparam logic [1:0] CODE_REPEAT  = 2'b11;
    localparam logic [1:0] CODE_LITERAL = 2'b01;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_FLUSH,
        OP_RUN_LO,
        OP_RUN_PIX,
        OP_CLOSE_HI,
        OP_CLOSE_LO,
        OP_LOAD_FINAL,
        OP_EOR,
        OP_OFS_HI,
        OP_OFS_LO,
        OP_OUT_ADV,
        OP_CLEAR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } pcre_cmd_t;

    typedef struct packed {
        logic close_pend;
        logic flush_pend;
        logic row_end;
        logic fl_multi;
        logic lit_nz;
        logic out_free;
        logic read_last;
    } pcre_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PLAN,
        S_FLUSH,
        S_RUN_LO,
        S_RUN_PIX,
        S_CLOSE_HI,
        S_CLOSE_LO,
        S_FINAL,
        S_EOR,
        S_OFS_HI,
        S_OFS_LO,
        S_OUT,
        S_CLEAR
    } pcre_state_t;

endpackage

FILE: design/pcre_ifs.sv
// ----------------------------------------------------------------------------
// pcre interfaces
// Valid/ready channels of the encoder: pixel input, packed byte output and
// the row width configuration write.
// ----------------------------------------------------------------------------
interface pcre_pix_if;
    logic       valid;
    logic       ready;
    logic [3:0] pixel_index;
    logic       final_row;

    modport source (output valid, output pixel_index, output final_row, input ready);
    modport sink   (input valid, input pixel_index, input final_row, output ready);
endinterface

interface pcre_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       row_last;
    logic       sprite_last;

    modport source (output valid, output out_byte, output row_last, output sprite_last,
                    input ready);
    modport sink   (input valid, input out_byte, input row_last, input sprite_last,
                    output ready);
endinterface

interface pcre_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] row_width;

    modport source (output valid, output row_width, input ready);
    modport sink   (input valid, input row_width, output ready);
endinterface

FILE: design/packed_cel_row_rle_encoder.sv
// ----------------------------------------------------------------------------
// packed_cel_row_rle_encoder
// Run-length encodes rows of 4-bit palette indices into packed cel rows:
// offset field, repeat and literal packets, end-of-row nibble, word padding,
// emitted as bytes MSB first at each row end.
//
//   channel       dir   word                                    handshake
//   cfg           in    row_width[5:0]                          valid/ready
//   pixels        in    pixel_index[3:0], final_row             valid/ready
//   packed_bytes  out   out_byte[7:0], row_last, sprite_last    valid/ready
//
// the nibble row buffer has a single write port, so packet nibbles are
// written one at a time, and a new pixel is taken only once the writes
// for the last one are done. the row buffer is never cleared: nibbles past
// the written end read as zero. a stalled output holds the readout; cfg is
// always ready.
// ----------------------------------------------------------------------------
module packed_cel_row_rle_encoder
    import pcre_pkg::*;
#(
    parameter int MAX_ROW_PIXELS   = MAX_ROW_PIXELS_DEF,
    parameter int ROW_BUFFER_BYTES = ROW_BUFFER_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    pcre_cfg_if.sink    cfg,
    pcre_pix_if.sink    pixels,
    pcre_byte_if.source packed_bytes
);

    pcre_cmd_t    cmd;
    pcre_status_t status;
    logic         in_ready;

    assign cfg.ready    = 1'b1;
    assign pixels.ready = in_ready;

    pcre_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixels.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pcre_datapath #(
        .MAX_ROW_PIXELS   (MAX_ROW_PIXELS),
        .ROW_BUFFER_BYTES (ROW_BUFFER_BYTES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg.valid),
        .cfg_row_width (cfg.row_width),
        .pixel_index   (pixels.pixel_index),
        .final_row     (pixels.final_row),
        .out_valid     (packed_bytes.valid),
        .out_byte      (packed_bytes.out_byte),
        .row_last      (packed_bytes.row_last),
        .sprite_last   (packed_bytes.sprite_last),
        .out_ready     (packed_bytes.ready)
    );

endmodule

FILE: design/pcre_datapath.sv
// ----------------------------------------------------------------------------
// pcre_datapath
// Run state, nibble row buffer, packet nibble writes, row length math and the
// byte readout register, driven one operation per cycle by the controller.
// ----------------------------------------------------------------------------
module pcre_datapath
    import pcre_pkg::*;
#(
    parameter int MAX_ROW_PIXELS   = MAX_ROW_PIXELS_DEF,
    parameter int ROW_BUFFER_BYTES = ROW_BUFFER_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  pcre_cmd_t              cmd,
    output pcre_status_t           status,
    input  logic                   cfg_valid,
    input  logic [ROW_WIDTH_W-1:0] cfg_row_width,
    input  logic [PIXEL_W-1:0]     pixel_index,
    input  logic                   final_row,
    output logic                   out_valid,
    output logic [BYTE_W-1:0]      out_byte,
    output logic                   row_last,
    output logic                   sprite_last,
    input  logic                   out_ready
);

    localparam int CNT_W     = $clog2(MAX_ROW_PIXELS + 1);
    localparam int NIB_W     = $clog2(3 * MAX_ROW_PIXELS + 12);
    localparam int NIB_DEPTH = 2 * ROW_BUFFER_BYTES;
    localparam int NA_W      = $clog2(NIB_DEPTH);
    localparam int BI_W      = $clog2(ROW_BUFFER_BYTES);

    localparam logic [7:0]  MAX_PIX8   = 8'(MAX_ROW_PIXELS);
    localparam logic [15:0] DEPTH16    = 16'(NIB_DEPTH);
    localparam logic [15:0] BUF_BYTES16 = 16'(ROW_BUFFER_BYTES);

    logic [ROW_WIDTH_W-1:0] row_width_reg, row_width_next;
    logic                   fin_reg, fin_next;
    logic [CNT_W-1:0]       col_reg, col_next;
    logic [PIXEL_W-1:0]     val_reg, val_next;
    logic [CNT_W-1:0]       len_reg, len_next;
    logic [PIXEL_W-1:0]     fl_val_reg, fl_val_next;
    logic [CNT_W-1:0]       fl_len_reg, fl_len_next;
    logic [CNT_W-1:0]       lit_reg, lit_next;
    logic [NIB_W-1:0]       hdr_reg, hdr_next;
    logic [NIB_W-1:0]       wpos_reg, wpos_next;
    logic                   flush_pend_reg, flush_pend_next;
    logic                   close_pend_reg, close_pend_next;
    logic                   row_end_reg, row_end_next;
    logic [NIB_W-1:0]       lim_reg, lim_next;
    logic [NIB_W-1:0]       words_reg, words_next;
    logic [BI_W-1:0]        last_idx_reg, last_idx_next;
    logic [BI_W-1:0]        rd_k_reg, rd_k_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   row_last_reg, row_last_next;
    logic                   sprite_last_reg, sprite_last_next;
    logic                   mask_hi_reg, mask_hi_next;
    logic                   mask_lo_reg, mask_lo_next;
    logic [NIB_BITS-1:0]    rd_hi_reg;
    logic [NIB_BITS-1:0]    rd_lo_reg;

    logic [NIB_BITS-1:0]    mem [NIB_DEPTH];

    logic                   we;
    logic [NIB_W-1:0]       waddr;
    logic [NIB_BITS-1:0]    wdata;
    logic [15:0]            waddr16;
    logic [7:0]             eff8;
    logic [7:0]             rw8;
    logic [CNT_W-1:0]       col_inc;
    logic [7:0]             fl_m8;
    logic [7:0]             lit_m8;
    logic [15:0]            n16;
    logic [15:0]            w16;
    logic [15:0]            b16;
    logic [15:0]            last16;
    logic [15:0]            ofs16;
    logic [NA_W-1:0]        ra_hi;
    logic [NA_W-1:0]        ra_lo;

    always_comb
    begin
        rw8 = {2'b00, row_width_reg};
        if (rw8 == 8'd0)
        begin
            eff8 = 8'd1;
        end
        else if (rw8 > MAX_PIX8)
        begin
            eff8 = MAX_PIX8;
        end
        else
        begin
            eff8 = rw8;
        end
    end

    assign col_inc = col_reg + CNT_W'(1);
    assign fl_m8   = 8'(fl_len_reg) - 8'd1;
    assign lit_m8  = 8'(lit_reg) - 8'd1;
    assign ofs16   = 16'(words_reg) - 16'd2;
    assign ra_hi   = {rd_k_reg, 1'b0};
    assign ra_lo   = {rd_k_reg, 1'b1};

    // row length in words, at least two, and the byte count it gives, capped at the buffer size
    always_comb
    begin
        n16 = 16'(wpos_reg) + 16'd1;
        w16 = (n16 + 16'd7) >> 3;
        if (w16 < 16'd2)
        begin
            w16 = 16'd2;
        end
        b16 = w16 << 2;
        if (b16 > BUF_BYTES16)
        begin
            b16 = BUF_BYTES16;
        end
        last16 = b16 - 16'd1;
    end

    always_comb
    begin
        row_width_next   = row_width_reg;
        fin_next         = fin_reg;
        col_next         = col_reg;
        val_next         = val_reg;
        len_next         = len_reg;
        fl_val_next      = fl_val_reg;
        fl_len_next      = fl_len_reg;
        lit_next         = lit_reg;
        hdr_next         = hdr_reg;
        wpos_next        = wpos_reg;
        flush_pend_next  = flush_pend_reg;
        close_pend_next  = close_pend_reg;
        row_end_next     = row_end_reg;
        lim_next         = lim_reg;
        words_next       = words_reg;
        last_idx_next    = last_idx_reg;
        rd_k_next        = rd_k_reg;
        out_valid_next   = out_valid_reg;
        row_last_next    = row_last_reg;
        sprite_last_next = sprite_last_reg;
        mask_hi_next     = mask_hi_reg;
        mask_lo_next     = mask_lo_reg;
        we               = 1'b0;
        waddr            = wpos_reg;
        wdata            = '0;

        if (cfg_valid)
        begin
            row_width_next = cfg_row_width;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (cmd.op)
            OP_ACCEPT:
            begin
                fin_next        = final_row;
                col_next        = col_inc;
                row_end_next    = 8'(col_inc) >= eff8;
                flush_pend_next = 1'b0;
                close_pend_next = 1'b0;
                if (len_reg == '0)
                begin
                    val_next = pixel_index;
                    len_next = CNT_W'(1);
                end
                else if (pixel_index == val_reg)
                begin
                    len_next        = len_reg + CNT_W'(1);
                    close_pend_next = (len_reg == CNT_W'(1));
                end
                else
                begin
                    fl_val_next     = val_reg;
                    fl_len_next     = len_reg;
                    flush_pend_next = 1'b1;
                    val_next        = pixel_index;
                    len_next        = CNT_W'(1);
                end
            end
            OP_FLUSH:
            begin
                we = 1'b1;
                if (fl_len_reg > CNT_W'(1))
                begin
                    waddr     = wpos_reg;
                    wdata     = {CODE_REPEAT, fl_m8[5:4]};
                    wpos_next = wpos_reg + NIB_W'(1);
                end
                else
                begin
                    lit_next = lit_reg + CNT_W'(1);
                    wdata    = fl_val_reg;
                    if (lit_reg == '0)
                    begin
                        hdr_next  = wpos_reg;
                        waddr     = wpos_reg + NIB_W'(2);
                        wpos_next = wpos_reg + NIB_W'(3);
                    end
                    else
                    begin
                        waddr     = wpos_reg;
                        wpos_next = wpos_reg + NIB_W'(1);
                    end
                end
            end
            OP_RUN_LO:
            begin
                we        = 1'b1;
                waddr     = wpos_reg;
                wdata     = fl_m8[3:0];
                wpos_next = wpos_reg + NIB_W'(1);
            end
            OP_RUN_PIX:
            begin
                we        = 1'b1;
                waddr     = wpos_reg;
                wdata     = fl_val_reg;
                wpos_next = wpos_reg + NIB_W'(1);
            end
            OP_CLOSE_HI:
            begin
                we    = 1'b1;
                waddr = hdr_reg;
                wdata = {CODE_LITERAL, lit_m8[5:4]};
            end
            OP_CLOSE_LO:
            begin
                we       = 1'b1;
                waddr    = hdr_reg + NIB_W'(1);
                wdata    = lit_m8[3:0];
                lit_next = '0;
            end
            OP_LOAD_FINAL:
            begin
                fl_val_next = val_reg;
                fl_len_next = len_reg;
            end
            OP_EOR:
            begin
                lim_next      = wpos_reg;
                wpos_next     = wpos_reg + NIB_W'(1);
                words_next    = w16[NIB_W-1:0];
                last_idx_next = last16[BI_W-1:0];
                rd_k_next     = '0;
            end
            OP_OFS_HI:
            begin
                we    = 1'b1;
                waddr = '0;
                wdata = ofs16[7:4];
            end
            OP_OFS_LO:
            begin
                we    = 1'b1;
                waddr = NIB_W'(1);
                wdata = ofs16[3:0];
            end
            OP_OUT_ADV:
            begin
                out_valid_next   = 1'b1;
                row_last_next    = (rd_k_reg == last_idx_reg);
                sprite_last_next = (rd_k_reg == last_idx_reg) && fin_reg;
                mask_hi_next     = 16'(ra_hi) < 16'(lim_reg);
                mask_lo_next     = 16'(ra_lo) < 16'(lim_reg);
                rd_k_next        = rd_k_reg + BI_W'(1);
            end
            OP_CLEAR:
            begin
                col_next  = '0;
                val_next  = '0;
                len_next  = '0;
                lit_next  = '0;
                hdr_next  = '0;
                wpos_next = NIB_W'(2);
            end
            default:
            begin
            end
        endcase
    end

    assign waddr16 = 16'(waddr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg   <= ROW_WIDTH_RST;
            fin_reg         <= 1'b0;
            col_reg         <= '0;
            val_reg         <= '0;
            len_reg         <= '0;
            fl_val_reg      <= '0;
            fl_len_reg      <= '0;
            lit_reg         <= '0;
            hdr_reg         <= '0;
            wpos_reg        <= NIB_W'(2);
            flush_pend_reg  <= 1'b0;
            close_pend_reg  <= 1'b0;
            row_end_reg     <= 1'b0;
            lim_reg         <= '0;
            words_reg       <= NIB_W'(2);
            last_idx_reg    <= '0;
            rd_k_reg        <= '0;
            out_valid_reg   <= 1'b0;
            row_last_reg    <= 1'b0;
            sprite_last_reg <= 1'b0;
            mask_hi_reg     <= 1'b0;
            mask_lo_reg     <= 1'b0;
        end
        else
        begin
            row_width_reg   <= row_width_next;
            fin_reg         <= fin_next;
            col_reg         <= col_next;
            val_reg         <= val_next;
            len_reg         <= len_next;
            fl_val_reg      <= fl_val_next;
            fl_len_reg      <= fl_len_next;
            lit_reg         <= lit_next;
            hdr_reg         <= hdr_next;
            wpos_reg        <= wpos_next;
            flush_pend_reg  <= flush_pend_next;
            close_pend_reg  <= close_pend_next;
            row_end_reg     <= row_end_next;
            lim_reg         <= lim_next;
            words_reg       <= words_next;
            last_idx_reg    <= last_idx_next;
            rd_k_reg        <= rd_k_next;
            out_valid_reg   <= out_valid_next;
            row_last_reg    <= row_last_next;
            sprite_last_reg <= sprite_last_next;
            mask_hi_reg     <= mask_hi_next;
            mask_lo_reg     <= mask_lo_next;
        end
    end

    // nibble row buffer, writes past the end are dropped
    always_ff @(posedge clk)
    begin
        if (we && (waddr16 < DEPTH16))
        begin
            mem[waddr16[NA_W-1:0]] <= wdata;
        end
        if (cmd.op == OP_OUT_ADV)
        begin
            rd_hi_reg <= mem[ra_hi];
            rd_lo_reg <= mem[ra_lo];
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = {rd_hi_reg & {NIB_BITS{mask_hi_reg}}, rd_lo_reg & {NIB_BITS{mask_lo_reg}}};
    assign row_last    = row_last_reg;
    assign sprite_last = sprite_last_reg;

    assign status.close_pend = close_pend_reg;
    assign status.flush_pend = flush_pend_reg;
    assign status.row_end    = row_end_reg;
    assign status.fl_multi   = fl_len_reg > CNT_W'(1);
    assign status.lit_nz     = lit_reg != '0;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.read_last  = rd_k_reg == last_idx_reg;

    a_read_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT_ADV) |-> (rd_k_reg <= last_idx_reg))
        else $error("readout past row end");

    a_hdr_behind: assert property (@(posedge clk) disable iff (!rst_n)
        (lit_reg != '0) |-> ((16'(hdr_reg) + 16'd2) <= 16'(wpos_reg)))
        else $error("literal header not behind write pointer");

    a_run_le_col: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= col_reg)
        else $error("run longer than row so far");

    a_sprite_row: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sprite_last_reg) |-> row_last_reg)
        else $error("sprite end off row end");

endmodule

FILE: design/pcre_ctrl.sv
// ----------------------------------------------------------------------------
// pcre_ctrl
// Controller of the encoder: takes a pixel, then steps the datapath through
// the packet nibble writes, the row end sequence and the byte readout.
// ----------------------------------------------------------------------------
module pcre_ctrl
    import pcre_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  pcre_status_t status,
    output pcre_cmd_t    cmd
);

    pcre_state_t state_reg, state_next;
    logic        end_phase_reg, end_phase_next;
    pcre_state_t after_flush;
    pcre_state_t after_close;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            end_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            end_phase_reg <= end_phase_next;
        end
    end

    always_comb
    begin
        if (end_phase_reg)
        begin
            after_flush = S_CLOSE_HI;
            after_close = S_EOR;
        end
        else if (status.row_end)
        begin
            after_flush = S_FINAL;
            after_close = S_FINAL;
        end
        else
        begin
            after_flush = S_IDLE;
            after_close = S_IDLE;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        end_phase_next = end_phase_reg;
        in_ready       = 1'b0;
        cmd.op         = OP_NONE;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op         = OP_ACCEPT;
                    end_phase_next = 1'b0;
                    state_next     = S_PLAN;
                end
            end
            S_PLAN:
            begin
                priority if (status.close_pend)
                begin
                    state_next = S_CLOSE_HI;
                end
                else if (status.flush_pend)
                begin
                    state_next = S_FLUSH;
                end
                else if (status.row_end)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                cmd.op     = OP_FLUSH;
                state_next = status.fl_multi ? S_RUN_LO : after_flush;
            end
            S_RUN_LO:
            begin
                cmd.op     = OP_RUN_LO;
                state_next = S_RUN_PIX;
            end
            S_RUN_PIX:
            begin
                cmd.op     = OP_RUN_PIX;
                state_next = after_flush;
            end
            S_CLOSE_HI:
            begin
                if (status.lit_nz)
                begin
                    cmd.op     = OP_CLOSE_HI;
                    state_next = S_CLOSE_LO;
                end
                else
                begin
                    state_next = after_close;
                end
            end
            S_CLOSE_LO:
            begin
                cmd.op     = OP_CLOSE_LO;
                state_next = after_close;
            end
            S_FINAL:
            begin
                cmd.op         = OP_LOAD_FINAL;
                end_phase_next = 1'b1;
                state_next     = S_FLUSH;
            end
            S_EOR:
            begin
                cmd.op     = OP_EOR;
                state_next = S_OFS_HI;
            end
            S_OFS_HI:
            begin
                cmd.op     = OP_OFS_HI;
                state_next = S_OFS_LO;
            end
            S_OFS_LO:
            begin
                cmd.op     = OP_OFS_LO;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.op = OP_OUT_ADV;
                    if (status.read_last)
                    begin
                        state_next = S_CLEAR;
                    end
                end
            end
            S_CLEAR:
            begin
                cmd.op     = OP_CLEAR;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_ACCEPT) |-> (state_reg == S_IDLE && in_valid))
        else $error("pixel taken outside idle");

    a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> end_phase_reg)
        else $error("row cleared outside row end");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (cmd.op == OP_NONE || cmd.op == OP_ACCEPT))
        else $error("datapath busy in idle");

endmodule
